[sv/klq_pkg.sv]
// Shared types, constants and ROM functions for the keyboard line input queue.
// No dependencies; every other file imports this package.
`default_nettype none

package klq_pkg;

    // Character queue geometry
    localparam int QUEUE_DEPTH = 1024;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam int CHAR_W = 7;
    localparam int CODE_W = 8;
    localparam int ECHO_W = 16;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'h08;

    typedef enum logic [1:0] {
        CMD_KEY        = 2'd0,
        CMD_READ       = 2'd1,
        CMD_ECHO_RESET = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOT_CHAR = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_DIGIT  = 2'd1,
        KIND_LETTER = 2'd2,
        KIND_SYMBOL = 2'd3
    } kind_t;

    // One classified transaction waiting for the back end
    typedef struct packed {
        cmd_t              cmd;
        logic              is_char;
        logic [CHAR_W-1:0] ch;
    } cmd_entry_t;

    // Sort a make code into digit, letter, symbol or other
    function automatic kind_t classify(input logic [CODE_W-1:0] code);
        kind_t k;
        k = KIND_OTHER;
        if (code >= 8'd2 && code <= 8'd11)
            k = KIND_DIGIT;
        else if ((code >= 8'd16 && code <= 8'd25) || (code >= 8'd30 && code <= 8'd38) ||
                 (code >= 8'd44 && code <= 8'd50))
            k = KIND_LETTER;
        else if (code == 8'd1  || code == 8'd12 || code == 8'd13 || code == 8'd14 ||
                 code == 8'd15 || code == 8'd26 || code == 8'd27 || code == 8'd28 ||
                 code == 8'd39 || code == 8'd40 || code == 8'd41 || code == 8'd43 ||
                 code == 8'd51 || code == 8'd52 || code == 8'd53 || code == 8'd57)
            k = KIND_SYMBOL;
        return k;
    endfunction

    // Unshifted character ROM
    function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            7'd1:    c = 7'h1B;
            7'd2:    c = 7'h31;
            7'd3:    c = 7'h32;
            7'd4:    c = 7'h33;
            7'd5:    c = 7'h34;
            7'd6:    c = 7'h35;
            7'd7:    c = 7'h36;
            7'd8:    c = 7'h37;
            7'd9:    c = 7'h38;
            7'd10:   c = 7'h39;
            7'd11:   c = 7'h30;
            7'd12:   c = 7'h2D;
            7'd13:   c = 7'h3D;
            7'd14:   c = 7'h08;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h71;
            7'd17:   c = 7'h77;
            7'd18:   c = 7'h65;
            7'd19:   c = 7'h72;
            7'd20:   c = 7'h74;
            7'd21:   c = 7'h79;
            7'd22:   c = 7'h75;
            7'd23:   c = 7'h69;
            7'd24:   c = 7'h6F;
            7'd25:   c = 7'h70;
            7'd26:   c = 7'h5B;
            7'd27:   c = 7'h5D;
            7'd28:   c = 7'h0A;
            7'd30:   c = 7'h61;
            7'd31:   c = 7'h73;
            7'd32:   c = 7'h64;
            7'd33:   c = 7'h66;
            7'd34:   c = 7'h67;
            7'd35:   c = 7'h68;
            7'd36:   c = 7'h6A;
            7'd37:   c = 7'h6B;
            7'd38:   c = 7'h6C;
            7'd39:   c = 7'h3B;
            7'd40:   c = 7'h27;
            7'd41:   c = 7'h60;
            7'd43:   c = 7'h5C;
            7'd44:   c = 7'h7A;
            7'd45:   c = 7'h78;
            7'd46:   c = 7'h63;
            7'd47:   c = 7'h76;
            7'd48:   c = 7'h62;
            7'd49:   c = 7'h6E;
            7'd50:   c = 7'h6D;
            7'd51:   c = 7'h2C;
            7'd52:   c = 7'h2E;
            7'd53:   c = 7'h2F;
            7'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Shifted character ROM
    function automatic logic [CHAR_W-1:0] shifted_char(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            7'd1:    c = 7'h1B;
            7'd2:    c = 7'h21;
            7'd3:    c = 7'h40;
            7'd4:    c = 7'h23;
            7'd5:    c = 7'h24;
            7'd6:    c = 7'h25;
            7'd7:    c = 7'h5E;
            7'd8:    c = 7'h26;
            7'd9:    c = 7'h2A;
            7'd10:   c = 7'h28;
            7'd11:   c = 7'h29;
            7'd12:   c = 7'h5F;
            7'd13:   c = 7'h2B;
            7'd14:   c = 7'h08;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h51;
            7'd17:   c = 7'h57;
            7'd18:   c = 7'h45;
            7'd19:   c = 7'h52;
            7'd20:   c = 7'h54;
            7'd21:   c = 7'h59;
            7'd22:   c = 7'h55;
            7'd23:   c = 7'h49;
            7'd24:   c = 7'h4F;
            7'd25:   c = 7'h50;
            7'd26:   c = 7'h7B;
            7'd27:   c = 7'h7D;
            7'd28:   c = 7'h0A;
            7'd30:   c = 7'h41;
            7'd31:   c = 7'h53;
            7'd32:   c = 7'h44;
            7'd33:   c = 7'h46;
            7'd34:   c = 7'h47;
            7'd35:   c = 7'h48;
            7'd36:   c = 7'h4A;
            7'd37:   c = 7'h4B;
            7'd38:   c = 7'h4C;
            7'd39:   c = 7'h3A;
            7'd40:   c = 7'h22;
            7'd41:   c = 7'h7E;
            7'd43:   c = 7'h7C;
            7'd44:   c = 7'h5A;
            7'd45:   c = 7'h58;
            7'd46:   c = 7'h43;
            7'd47:   c = 7'h56;
            7'd48:   c = 7'h42;
            7'd49:   c = 7'h4E;
            7'd50:   c = 7'h4D;
            7'd51:   c = 7'h3C;
            7'd52:   c = 7'h3E;
            7'd53:   c = 7'h3F;
            7'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/klq_front.sv]
// Front end: classifies an incoming transaction and looks up its character.
// Depends on klq_pkg.
`default_nettype none

module klq_front
    import klq_pkg::*;
(
    input  wire logic [1:0]        command,
    input  wire logic [CODE_W-1:0] scan_code,
    input  wire logic              shift_held,
    input  wire logic              caps_lock,
    input  wire logic              num_lock,
    output cmd_entry_t             entry
);

    kind_t kind;
    logic  use_shift;

    // Pick the table per key class
    always_comb
    begin
        kind = classify(scan_code);
        case (kind)
            KIND_DIGIT:  use_shift = (shift_held == num_lock);
            KIND_LETTER: use_shift = shift_held ^ caps_lock;
            KIND_SYMBOL: use_shift = shift_held;
            default:     use_shift = 1'b0;
        endcase
    end

    // Build the queued transaction
    always_comb
    begin
        entry.cmd     = cmd_t'(command);
        entry.is_char = (kind != KIND_OTHER);
        entry.ch      = use_shift ? shifted_char(scan_code[6:0])
                                  : plain_char(scan_code[6:0]);
    end

endmodule

`default_nettype wire

[sv/klq_cmd_queue.sv]
// Short queue of classified transactions between front and back end.
// Depends on klq_pkg.
`default_nettype none

module klq_cmd_queue
    import klq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire cmd_entry_t push_entry,
    input  wire logic       pop,
    output logic            full,
    output logic            not_empty,
    output cmd_entry_t      head_entry
);

    cmd_entry_t            slot_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]   head_reg, head_next;
    logic [CQ_PTR_W-1:0]   tail_reg, tail_next;
    logic [CQ_CNT_W-1:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_entry = slot_reg[head_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Hold entries until popped
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

[sv/klq_back.sv]
// Back end: character FIFO memory, line and echo counters, result registers.
// Depends on klq_pkg.
`default_nettype none

module klq_back
    import klq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    input  wire cmd_entry_t   q_entry,
    output logic              q_pop,
    output logic              done,
    output logic [1:0]        status,
    output logic [CHAR_W-1:0] char_out,
    output logic              echo_valid,
    output logic [CHAR_W-1:0] echo_char,
    output logic              line_ready,
    output logic [CNT_W-1:0]  queue_count
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_READ = 2'b10
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   line_reg, line_next;
    logic [ECHO_W-1:0]  echo_cnt_reg, echo_cnt_next;

    logic [CHAR_W-1:0]  mem [QUEUE_DEPTH];
    logic [CHAR_W-1:0]  rd_data_reg;
    logic               wr_en;
    logic               rd_en;

    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               echo_v_reg, echo_v_next;
    logic [CHAR_W-1:0]  echo_c_reg, echo_c_next;
    logic               line_rdy_reg, line_rdy_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Execute the head transaction
    always_comb
    begin
        state_next    = state_reg;
        wptr_next     = wptr_reg;
        rptr_next     = rptr_reg;
        fill_next     = fill_reg;
        line_next     = line_reg;
        echo_cnt_next = echo_cnt_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        q_pop         = 1'b0;
        done_next     = 1'b0;
        status_next   = STAT_OK;
        char_next     = '0;
        echo_v_next   = 1'b0;
        echo_c_next   = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_entry.cmd)
                        CMD_KEY:
                        begin
                            done_next = 1'b1;
                            if (!q_entry.is_char)
                            begin
                                status_next = STAT_NOT_CHAR;
                            end
                            else
                            begin
                                char_next = q_entry.ch;
                                if (fill_reg == CNT_W'(QUEUE_DEPTH))
                                begin
                                    status_next = STAT_FULL;
                                end
                                else
                                begin
                                    wr_en     = 1'b1;
                                    wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                                              ? '0 : wptr_reg + 1'b1;
                                    fill_next = fill_reg + 1'b1;
                                    if (q_entry.ch == CH_NEWLINE)
                                    begin
                                        line_next = line_reg + 1'b1;
                                    end
                                end
                                // Echo, bounded backspace
                                if (q_entry.ch == CH_NEWLINE)
                                begin
                                    echo_v_next   = 1'b1;
                                    echo_c_next   = q_entry.ch;
                                    echo_cnt_next = '0;
                                end
                                else if (q_entry.ch == CH_BACKSPACE)
                                begin
                                    if (echo_cnt_reg != '0)
                                    begin
                                        echo_cnt_next = echo_cnt_reg - 1'b1;
                                        echo_v_next   = 1'b1;
                                        echo_c_next   = q_entry.ch;
                                    end
                                end
                                else
                                begin
                                    if (echo_cnt_reg != '1)
                                    begin
                                        echo_cnt_next = echo_cnt_reg + 1'b1;
                                    end
                                    echo_v_next = 1'b1;
                                    echo_c_next = q_entry.ch;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            if (fill_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rptr_next  = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                                           ? '0 : rptr_reg + 1'b1;
                                fill_next  = fill_reg - 1'b1;
                                state_next = B_READ;
                            end
                        end
                        CMD_ECHO_RESET:
                        begin
                            done_next     = 1'b1;
                            echo_cnt_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                // Finish the dequeue with the registered memory data
                done_next  = 1'b1;
                char_next  = rd_data_reg;
                if (rd_data_reg == CH_NEWLINE && line_reg != '0)
                begin
                    line_next = line_reg - 1'b1;
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        line_rdy_next = (line_next != '0);
        count_next    = fill_next;
    end

    // Control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            fill_reg     <= '0;
            line_reg     <= '0;
            echo_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            fill_reg     <= fill_next;
            line_reg     <= line_next;
            echo_cnt_reg <= echo_cnt_next;
            done_reg     <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            status_reg   <= status_next;
            char_reg     <= char_next;
            echo_v_reg   <= echo_v_next;
            echo_c_reg   <= echo_c_next;
            line_rdy_reg <= line_rdy_next;
            count_reg    <= count_next;
        end
    end

    // Character memory, one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= q_entry.ch;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rptr_reg];
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign char_out    = char_reg;
    assign echo_valid  = echo_v_reg;
    assign echo_char   = echo_c_reg;
    assign line_ready  = line_rdy_reg;
    assign queue_count = count_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    // The line count of a dequeued newline drops in the cycle after the fill count does
    a_lines_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (line_reg <= fill_reg) || (state_reg == B_READ))
        else $error("more complete lines than characters held");

    a_read_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_READ) |=> (state_reg == B_IDLE) && done_reg)
        else $error("dequeue did not complete in one cycle");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(q_pop) || $past(state_reg == B_READ))
        else $error("result strobe without a transaction");

endmodule

`default_nettype wire

[sv/keyboard_line_input_queue_unit.sv]
// Top level of the keyboard line input queue: front decode, command queue, back end.
// Depends on klq_pkg, klq_front, klq_cmd_queue and klq_back.
`default_nettype none

// A transaction is taken on a rising edge with start high and busy low. The front
// decodes the scan code straight into a two-entry command queue; busy is high only
// while that queue is full. The back end retires a key event, echo reset, no-op or
// empty read straight from its idle state, and a character read through a second
// state that returns the data from the character memory's registered read port;
// a transaction queued behind others waits for them. Results come in order, each
// marked by done for one cycle. The receiver cannot stall: results must be captured
// when done is high. line_ready and queue_count reflect the queue after that
// transaction.
module keyboard_line_input_queue_unit
    import klq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        command,
    input  wire logic [CODE_W-1:0] scan_code,
    input  wire logic              shift_held,
    input  wire logic              caps_lock,
    input  wire logic              num_lock,
    output logic                   done,
    output logic [1:0]             status,
    output logic [CHAR_W-1:0]      char_out,
    output logic                   echo_valid,
    output logic [CHAR_W-1:0]      echo_char,
    output logic                   line_ready,
    output logic [CNT_W-1:0]       queue_count
);

    cmd_entry_t front_entry;
    cmd_entry_t head_entry;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;

    klq_front u_front (
        .command    (command),
        .scan_code  (scan_code),
        .shift_held (shift_held),
        .caps_lock  (caps_lock),
        .num_lock   (num_lock),
        .entry      (front_entry)
    );

    klq_cmd_queue u_cmd_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (start),
        .push_entry (front_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head_entry (head_entry)
    );

    klq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_entry     (head_entry),
        .q_pop       (q_pop),
        .done        (done),
        .status      (status),
        .char_out    (char_out),
        .echo_valid  (echo_valid),
        .echo_char   (echo_char),
        .line_ready  (line_ready),
        .queue_count (queue_count)
    );

    assign busy = q_full;

endmodule

`default_nettype wire
